### hw/rtl/ght_pkg.sv
// shared codes and constants of the generational handle table
`timescale 1ns / 1ps
`default_nettype none

package ght_pkg;

    // command codes
    localparam logic [2:0] CMD_CREATE   = 3'd0;
    localparam logic [2:0] CMD_DUP      = 3'd1;
    localparam logic [2:0] CMD_RESTRICT = 3'd2;
    localparam logic [2:0] CMD_REMOVE   = 3'd3;
    localparam logic [2:0] CMD_TAKE     = 3'd4;
    localparam logic [2:0] CMD_VERIFY   = 3'd5;
    localparam logic [2:0] CMD_CLEAR    = 3'd6;

    // status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NULL    = 3'd1;
    localparam logic [2:0] ST_TYPE    = 3'd2;
    localparam logic [2:0] ST_RIGHTS  = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;
    localparam logic [2:0] ST_INVALID = 3'd5;

    // generation at which a closed slot is retired
    localparam logic [30:0] GEN_MAX = 31'h7FFF_FFFF;

    // sequencer states, one-hot
    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_LOOK   = 7'b0000010,
        S_ACHK   = 7'b0000100,
        S_ALLOC  = 7'b0001000,
        S_CLR_RD = 7'b0010000,
        S_CLR_WR = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

endpackage

`default_nettype wire

### hw/rtl/ght_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module ght_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/generational_handle_table.sv
// Generational handle table: slots with object, type, rights, generation
// and a LIFO free list, all held in one slot memory.
// Input channel (in_valid/in_ready) takes one command per transfer; the
// output channel (out_valid/out_ready) returns exactly one result each.
// The configuration channel (cfg_valid/cfg_ready) writes the duplicate
// right mask; it is always ready and reset sets it to 1.
// Verify, restrict, remove and take look up the slot, write it back where
// needed and finish; create runs its checks, then pops the free head and
// fills it; duplicate looks up, then does as create. Each slot access is a
// registered read of the slot memory followed by a write back. Commands run one
// at a time; a new one is taken while the previous result still waits.
// The next command is taken in the idle state that follows a result load.
// Clear walks the slots that were ever handed out, each with a read state
// and a write back state, from the fill mark down to slot zero.
// Reset needs no clearing pass: a fill mark separates slots never used,
// which read as empty with an ascending link, from slots in the memory.
// A stalled receiver holds the result register; the next command then
// finishes its work and waits in its last state until the register frees.
`timescale 1ns / 1ps
`default_nettype none

module generational_handle_table
    import ght_pkg::*;
#(
    parameter int CAPACITY = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  command,
    input  wire logic [31:0] slot_index,
    input  wire logic [30:0] handle_generation,
    input  wire logic [31:0] rights_operand,
    input  wire logic [31:0] new_object,
    input  wire logic [15:0] object_type,
    input  wire logic        type_known,
    input  wire logic [31:0] type_valid_rights,
    input  wire logic [15:0] wanted_type,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic [9:0]       out_index,
    output logic [30:0]      out_generation,
    output logic [31:0]      out_rights,
    output logic [31:0]      out_object,
    output logic [10:0]      live_handles
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LW = $clog2(CAPACITY + 1);
    localparam logic [LW-1:0] LINK_NONE = LW'(CAPACITY);

    typedef struct packed {
        logic [31:0]   obj;
        logic [15:0]   otype;
        logic [31:0]   rights;
        logic [30:0]   gen;
        logic [LW-1:0] next;
    } entry_t;

    localparam int DW = $bits(entry_t);

    // control state
    state_t        state_reg, state_next;
    logic [LW-1:0] head_reg, head_next;
    logic [LW-1:0] count_reg, count_next;
    logic [LW-1:0] fresh_reg, fresh_next;
    logic [LW-1:0] clr_i_reg, clr_i_next;
    logic [LW-1:0] clr_head_reg, clr_head_next;
    logic [31:0]   mask_reg, mask_next;
    logic          out_valid_reg, out_valid_next;

    // command payload
    logic [2:0]    cmd_reg, cmd_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic          inr_reg, inr_next;
    logic [30:0]   gen_reg, gen_next;
    logic [31:0]   rop_reg, rop_next;
    logic          known_reg, known_next;
    logic [31:0]   valid_reg, valid_next;
    logic [15:0]   etype_reg, etype_next;
    logic [31:0]   a_obj_reg, a_obj_next;
    logic [15:0]   a_type_reg, a_type_next;
    logic [31:0]   a_rights_reg, a_rights_next;
    logic [IW-1:0] rd_addr_reg, rd_addr_next;

    // result and output payload
    logic [2:0]    res_status_reg, res_status_next;
    logic [IW-1:0] res_index_reg, res_index_next;
    logic [30:0]   res_gen_reg, res_gen_next;
    logic [31:0]   res_rights_reg, res_rights_next;
    logic [31:0]   res_obj_reg, res_obj_next;
    logic [2:0]    o_status_reg, o_status_next;
    logic [IW-1:0] o_index_reg, o_index_next;
    logic [30:0]   o_gen_reg, o_gen_next;
    logic [31:0]   o_rights_reg, o_rights_next;
    logic [31:0]   o_obj_reg, o_obj_next;
    logic [LW-1:0] o_live_reg, o_live_next;

    // memory ports
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic [DW-1:0] rd_data;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    entry_t        wr_data;

    entry_t        raw;
    entry_t        cur;
    logic          hok;
    logic [LW-1:0] clr_dec;
    logic [30:0]   clr_gen;

    ght_ram #(
        .WIDTH (DW),
        .DEPTH (CAPACITY)
    ) u_slots (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // slots at or above the fill mark read as empty with an ascending link
    always_comb
    begin
        raw = entry_t'(rd_data);
        if (LW'(rd_addr_reg) >= fresh_reg)
        begin
            cur        = '0;
            cur.next   = LW'(rd_addr_reg) + LW'(1);
        end
        else
        begin
            cur = raw;
        end
    end

    assign hok     = inr_reg && (cur.gen == gen_reg) && (cur.obj != 32'd0);
    assign clr_dec = clr_i_reg - LW'(1);
    assign clr_gen = ((cur.obj != 32'd0) && (cur.gen != GEN_MAX)) ?
                     cur.gen + 31'd1 : cur.gen;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        fresh_next      = fresh_reg;
        clr_i_next      = clr_i_reg;
        clr_head_next   = clr_head_reg;
        mask_next       = mask_reg;
        out_valid_next  = out_valid_reg;
        cmd_next        = cmd_reg;
        idx_next        = idx_reg;
        inr_next        = inr_reg;
        gen_next        = gen_reg;
        rop_next        = rop_reg;
        known_next      = known_reg;
        valid_next      = valid_reg;
        etype_next      = etype_reg;
        a_obj_next      = a_obj_reg;
        a_type_next     = a_type_reg;
        a_rights_next   = a_rights_reg;
        rd_addr_next    = rd_addr_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        res_gen_next    = res_gen_reg;
        res_rights_next = res_rights_reg;
        res_obj_next    = res_obj_reg;
        o_status_next   = o_status_reg;
        o_index_next    = o_index_reg;
        o_gen_next      = o_gen_reg;
        o_rights_next   = o_rights_reg;
        o_obj_next      = o_obj_reg;
        o_live_next     = o_live_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = rd_addr_reg;
        wr_data         = cur;

        if (cfg_valid)
        begin
            mask_next = cfg_data;
        end
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next        = command;
                    idx_next        = slot_index[IW-1:0];
                    inr_next        = slot_index < 32'(CAPACITY);
                    gen_next        = handle_generation;
                    rop_next        = rights_operand;
                    known_next      = type_known;
                    valid_next      = type_valid_rights;
                    etype_next      = wanted_type;
                    res_status_next = ST_OK;
                    res_index_next  = '0;
                    res_gen_next    = '0;
                    res_rights_next = '0;
                    res_obj_next    = '0;
                    case (command)
                        CMD_CREATE:
                        begin
                            a_obj_next    = new_object;
                            a_type_next   = object_type;
                            a_rights_next = rights_operand;
                            state_next    = S_ACHK;
                        end
                        CMD_CLEAR:
                        begin
                            clr_i_next    = fresh_reg;
                            clr_head_next = fresh_reg;
                            state_next    = S_CLR_RD;
                        end
                        CMD_DUP, CMD_RESTRICT, CMD_REMOVE, CMD_TAKE, CMD_VERIFY:
                        begin
                            rd_en        = 1'b1;
                            rd_addr      = slot_index[IW-1:0];
                            rd_addr_next = slot_index[IW-1:0];
                            state_next   = S_LOOK;
                        end
                        default:
                        begin
                            res_status_next = ST_INVALID;
                            state_next      = S_DONE;
                        end
                    endcase
                end
            end

            S_LOOK:
            begin
                state_next = S_DONE;
                if (!hok)
                begin
                    res_status_next = ST_INVALID;
                end
                else
                begin
                    case (cmd_reg)
                        CMD_DUP:
                        begin
                            if ((cur.rights & mask_reg) == 32'd0)
                            begin
                                res_status_next = ST_RIGHTS;
                            end
                            else
                            begin
                                a_obj_next    = cur.obj;
                                a_type_next   = cur.otype;
                                a_rights_next = cur.rights & rop_reg;
                                state_next    = S_ACHK;
                            end
                        end
                        CMD_RESTRICT:
                        begin
                            if ((rop_reg & ~cur.rights) != 32'd0)
                            begin
                                res_status_next = ST_RIGHTS;
                            end
                            else
                            begin
                                wr_en          = 1'b1;
                                wr_data.rights = rop_reg;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            wr_en          = 1'b1;
                            wr_data.rights = cur.rights & ~rop_reg;
                        end
                        CMD_TAKE:
                        begin
                            res_obj_next    = cur.obj;
                            res_rights_next = cur.rights;
                            wr_en           = 1'b1;
                            wr_data.obj     = '0;
                            wr_data.rights  = '0;
                            count_next      = count_reg - LW'(1);
                            if (cur.gen == GEN_MAX)
                            begin
                                wr_data.next = LINK_NONE;
                            end
                            else
                            begin
                                wr_data.gen  = cur.gen + 31'd1;
                                wr_data.next = head_reg;
                                head_next    = LW'(idx_reg);
                            end
                        end
                        CMD_VERIFY:
                        begin
                            if ((etype_reg != 16'd0) && (cur.otype != etype_reg))
                            begin
                                res_status_next = ST_TYPE;
                            end
                            else if ((cur.rights & rop_reg) != rop_reg)
                            begin
                                res_status_next = ST_RIGHTS;
                            end
                            else
                            begin
                                res_obj_next    = cur.obj;
                                res_rights_next = cur.rights;
                            end
                        end
                        default:
                        begin
                            res_status_next = ST_INVALID;
                        end
                    endcase
                end
            end

            // create and duplicate checks, then fetch the free head
            S_ACHK:
            begin
                state_next = S_DONE;
                if (a_obj_reg == 32'd0)
                begin
                    res_status_next = ST_NULL;
                end
                else if (!known_reg)
                begin
                    res_status_next = ST_TYPE;
                end
                else if ((a_rights_reg & ~valid_reg) != 32'd0)
                begin
                    res_status_next = ST_RIGHTS;
                end
                else if (head_reg == LINK_NONE)
                begin
                    res_status_next = ST_FULL;
                end
                else
                begin
                    rd_en        = 1'b1;
                    rd_addr      = head_reg[IW-1:0];
                    rd_addr_next = head_reg[IW-1:0];
                    state_next   = S_ALLOC;
                end
            end

            // pop the free head and fill the slot
            S_ALLOC:
            begin
                wr_en          = 1'b1;
                wr_data.obj    = a_obj_reg;
                wr_data.otype  = a_type_reg;
                wr_data.rights = a_rights_reg;
                wr_data.gen    = cur.gen;
                wr_data.next   = LINK_NONE;
                head_next      = cur.next;
                count_next     = count_reg + LW'(1);
                if (LW'(rd_addr_reg) >= fresh_reg)
                begin
                    fresh_next = fresh_reg + LW'(1);
                end
                res_index_next = rd_addr_reg;
                res_gen_next   = cur.gen;
                state_next     = S_DONE;
            end

            // clear walk, from the fill mark down to slot zero
            S_CLR_RD:
            begin
                if (clr_i_reg == '0)
                begin
                    head_next  = clr_head_reg;
                    count_next = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en        = 1'b1;
                    rd_addr      = clr_dec[IW-1:0];
                    rd_addr_next = clr_dec[IW-1:0];
                    state_next   = S_CLR_WR;
                end
            end

            S_CLR_WR:
            begin
                wr_en          = 1'b1;
                wr_data.obj    = '0;
                wr_data.rights = '0;
                wr_data.gen    = clr_gen;
                if (clr_gen == GEN_MAX)
                begin
                    wr_data.next = LINK_NONE;
                end
                else
                begin
                    wr_data.next  = clr_head_reg;
                    clr_head_next = LW'(rd_addr_reg);
                end
                clr_i_next = clr_dec;
                state_next = S_CLR_RD;
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    o_status_next  = res_status_reg;
                    o_index_next   = res_index_reg;
                    o_gen_next     = res_gen_reg;
                    o_rights_next  = res_rights_reg;
                    o_obj_next     = res_obj_reg;
                    o_live_next    = count_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            fresh_reg     <= '0;
            clr_i_reg     <= '0;
            clr_head_reg  <= '0;
            mask_reg      <= 32'd1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            fresh_reg     <= fresh_next;
            clr_i_reg     <= clr_i_next;
            clr_head_reg  <= clr_head_next;
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        idx_reg        <= idx_next;
        inr_reg        <= inr_next;
        gen_reg        <= gen_next;
        rop_reg        <= rop_next;
        known_reg      <= known_next;
        valid_reg      <= valid_next;
        etype_reg      <= etype_next;
        a_obj_reg      <= a_obj_next;
        a_type_reg     <= a_type_next;
        a_rights_reg   <= a_rights_next;
        rd_addr_reg    <= rd_addr_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        res_gen_reg    <= res_gen_next;
        res_rights_reg <= res_rights_next;
        res_obj_reg    <= res_obj_next;
        o_status_reg   <= o_status_next;
        o_index_reg    <= o_index_next;
        o_gen_reg      <= o_gen_next;
        o_rights_reg   <= o_rights_next;
        o_obj_reg      <= o_obj_next;
        o_live_reg     <= o_live_next;
    end

    // port drive
    assign cfg_ready      = 1'b1;
    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign status         = o_status_reg;
    assign out_index      = 10'(o_index_reg);
    assign out_generation = o_gen_reg;
    assign out_rights     = o_rights_reg;
    assign out_object     = o_obj_reg;
    assign live_handles   = 11'(o_live_reg);

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= fresh_reg)
        else $error("occupied count above handed-out slots");

    a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fresh_reg <= LINK_NONE)
        else $error("fill mark beyond capacity");

    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_DONE) |-> !wr_en)
        else $error("slot write outside a working state");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != S_IDLE))
        else $error("command transfer did not start work");

    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !out_valid_reg) |=> out_valid_reg)
        else $error("finished result not loaded into free output");

endmodule

`default_nettype wire

### verif/testbench.sv
// self-checking testbench of the generational handle table
`timescale 1ns / 1ps

module testbench;
    import ght_pkg::*;

    localparam int SLOTS     = 1024;
    localparam int LINK_NONE = SLOTS;

    typedef struct {
        logic [2:0]  cmd;
        logic [31:0] idx;
        logic [30:0] gen;
        logic [31:0] rop;
        logic [31:0] obj;
        logic [15:0] otype;
        logic        known;
        logic [31:0] valid;
        logic [15:0] etype;
    } cmd_item_t;

    typedef struct {
        logic [2:0]  st;
        logic [9:0]  nidx;
        logic [30:0] ngen;
        logic [31:0] rights;
        logic [31:0] obj;
        logic [10:0] live;
    } answer_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  command;
    logic [31:0] slot_index;
    logic [30:0] handle_generation;
    logic [31:0] rights_operand;
    logic [31:0] new_object;
    logic [15:0] object_type;
    logic        type_known;
    logic [31:0] type_valid_rights;
    logic [15:0] wanted_type;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic [9:0]  out_index;
    logic [30:0] out_generation;
    logic [31:0] out_rights;
    logic [31:0] out_object;
    logic [10:0] live_handles;

    // shadow copy of the table
    logic [31:0] m_obj [SLOTS];
    logic [15:0] m_type [SLOTS];
    logic [31:0] m_rights [SLOTS];
    logic [30:0] m_gen [SLOTS];
    int          m_next [SLOTS];
    int          m_head;
    int          m_count;
    logic [31:0] m_dup_mask;

    answer_t     pending_answers[$];
    int          mismatches;
    int          idle_pct;
    int          stall_pct;
    int          hold_cycles;

    generational_handle_table i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .command           (command),
        .slot_index        (slot_index),
        .handle_generation (handle_generation),
        .rights_operand    (rights_operand),
        .new_object        (new_object),
        .object_type       (object_type),
        .type_known        (type_known),
        .type_valid_rights (type_valid_rights),
        .wanted_type       (wanted_type),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .status            (status),
        .out_index         (out_index),
        .out_generation    (out_generation),
        .out_rights        (out_rights),
        .out_object        (out_object),
        .live_handles      (live_handles)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit
    initial
    begin
        #4ms;
        $display("end of test: mismatches");
        $finish;
    end

    // receiver readiness, with long hold-offs on request
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_ready   <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // result checker, sampled mid-cycle ahead of the transfer edge
    always @(negedge clk)
    begin
        answer_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_answers.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result status %0d", status);
            end
            else
            begin
                want = pending_answers.pop_front();
                if (status !== want.st || out_index !== want.nidx
                    || out_generation !== want.ngen || out_rights !== want.rights
                    || out_object !== want.obj || live_handles !== want.live)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp st %0d idx %0d gen %h rt %h obj %h live %0d",
                                 want.st, want.nidx, want.ngen, want.rights, want.obj,
                                 want.live, "\n          got st %0d idx %0d gen %h rt %h",
                                 status, out_index, out_generation, out_rights,
                                 " obj %h live %0d", out_object, live_handles);
                end
            end
        end
    end

    // table reset state
    task automatic table_reset();
        for (int i = 0; i < SLOTS; i++)
        begin
            m_obj[i]    = '0;
            m_type[i]   = '0;
            m_rights[i] = '0;
            m_gen[i]    = '0;
            m_next[i]   = i + 1;
        end
        m_head     = 0;
        m_count    = 0;
        m_dup_mask = 32'd1;
    endtask

    function automatic bit handle_live(logic [31:0] idx, logic [30:0] gen);
        if (idx >= SLOTS)
            return 1'b0;
        return m_gen[idx] == gen && m_obj[idx] != '0;
    endfunction

    // slot allocation with the create checks
    function automatic logic [2:0] grab_slot(logic [31:0] obj, logic [15:0] typ,
                                             logic [31:0] rts, logic known,
                                             logic [31:0] allowed, inout answer_t a);
        int s;
        if (obj == '0)
            return ST_NULL;
        if (!known)
            return ST_TYPE;
        if ((rts & ~allowed) != '0)
            return ST_RIGHTS;
        if (m_head >= LINK_NONE)
            return ST_FULL;
        s           = m_head;
        m_head      = m_next[s];
        m_obj[s]    = obj;
        m_type[s]   = typ;
        m_rights[s] = rts;
        m_next[s]   = LINK_NONE;
        m_count++;
        a.nidx = s[9:0];
        a.ngen = m_gen[s];
        return ST_OK;
    endfunction

    // expected answer of one command, updating the shadow table
    function automatic answer_t table_answer(cmd_item_t c);
        answer_t a;
        int      k;
        a = '{ST_OK, '0, '0, '0, '0, '0};
        k = c.idx;
        case (c.cmd)
            CMD_CREATE:
                a.st = grab_slot(c.obj, c.otype, c.rop, c.known, c.valid, a);
            CMD_DUP:
                if (!handle_live(c.idx, c.gen))
                    a.st = ST_INVALID;
                else if ((m_rights[k] & m_dup_mask) == '0)
                    a.st = ST_RIGHTS;
                else
                    a.st = grab_slot(m_obj[k], m_type[k], m_rights[k] & c.rop,
                                     c.known, c.valid, a);
            CMD_RESTRICT:
                if (!handle_live(c.idx, c.gen))
                    a.st = ST_INVALID;
                else if ((c.rop & ~m_rights[k]) != '0)
                    a.st = ST_RIGHTS;
                else
                    m_rights[k] = c.rop;
            CMD_REMOVE:
                if (!handle_live(c.idx, c.gen))
                    a.st = ST_INVALID;
                else
                    m_rights[k] &= ~c.rop;
            CMD_TAKE:
                if (!handle_live(c.idx, c.gen))
                    a.st = ST_INVALID;
                else
                begin
                    a.obj       = m_obj[k];
                    a.rights    = m_rights[k];
                    m_obj[k]    = '0;
                    m_rights[k] = '0;
                    m_count--;
                    if (m_gen[k] == GEN_MAX)
                        m_next[k] = LINK_NONE;
                    else
                    begin
                        m_gen[k]++;
                        m_next[k] = m_head;
                        m_head    = k;
                    end
                end
            CMD_VERIFY:
                if (!handle_live(c.idx, c.gen))
                    a.st = ST_INVALID;
                else if (c.etype != '0 && m_type[k] != c.etype)
                    a.st = ST_TYPE;
                else if ((m_rights[k] & c.rop) != c.rop)
                    a.st = ST_RIGHTS;
                else
                begin
                    a.obj    = m_obj[k];
                    a.rights = m_rights[k];
                end
            CMD_CLEAR:
            begin
                for (int i = 0; i < SLOTS; i++)
                    if (m_obj[i] != '0)
                    begin
                        m_obj[i]    = '0;
                        m_rights[i] = '0;
                        if (m_gen[i] != GEN_MAX)
                            m_gen[i]++;
                    end
                m_count = 0;
                m_head  = LINK_NONE;
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (m_gen[i] == GEN_MAX)
                        m_next[i] = LINK_NONE;
                    else
                    begin
                        m_next[i] = m_head;
                        m_head    = i;
                    end
            end
            default:
                a.st = ST_INVALID;
        endcase
        a.live = m_count[10:0];
        return a;
    endfunction

    // one command transfer; valid stays high for a following item
    task automatic send_cmd(cmd_item_t c);
        bit taken;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid          <= 1'b1;
        command           <= c.cmd;
        slot_index        <= c.idx;
        handle_generation <= c.gen;
        rights_operand    <= c.rop;
        new_object        <= c.obj;
        object_type       <= c.otype;
        type_known        <= c.known;
        type_valid_rights <= c.valid;
        wanted_type       <= c.etype;
        do
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        while (!taken);
        pending_answers.insert(pending_answers.size(), table_answer(c));
    endtask

    // drain all results, then give the block spare idle time
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_dup_mask(logic [31:0] value);
        bit taken;
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
        while (!taken);
        m_dup_mask = value;
        cfg_valid <= 1'b0;
    endtask

    function automatic cmd_item_t make_cmd(logic [2:0] cmd, logic [31:0] idx,
                                           logic [31:0] rop, logic [31:0] obj,
                                           logic [15:0] otype);
        cmd_item_t c;
        c.cmd   = cmd;
        c.idx   = idx;
        c.gen   = (idx < SLOTS) ? m_gen[idx] : 31'd0;
        c.rop   = rop;
        c.obj   = obj;
        c.otype = otype;
        c.known = 1'b1;
        c.valid = '1;
        c.etype = '0;
        return c;
    endfunction

    // mostly well-formed commands on a small working set of slots
    function automatic cmd_item_t random_cmd();
        cmd_item_t c;
        int        pick;
        int        k;
        pick = $urandom_range(99);
        k    = $urandom_range(0, 47);
        if (pick < 30)
            c.cmd = CMD_CREATE;
        else if (pick < 98)
            c.cmd = 3'($urandom_range(CMD_DUP, CMD_VERIFY));
        else if (pick < 99)
            c.cmd = CMD_CLEAR;
        else
            c.cmd = 3'd7;
        c.idx   = ($urandom_range(9) == 0) ? $urandom() : k;
        c.gen   = ($urandom_range(9) == 0) ? 31'($urandom()) : m_gen[k];
        c.rop   = ($urandom_range(3) == 0) ? $urandom() : (m_rights[k] & $urandom());
        c.obj   = ($urandom_range(15) == 0) ? '0 : $urandom();
        c.otype = ($urandom_range(7) == 0) ? 16'($urandom()) : 16'($urandom_range(1, 4));
        c.known = ($urandom_range(15) != 0);
        c.valid = ($urandom_range(5) == 0) ? $urandom() : '1;
        case ($urandom_range(3))
            0: c.etype = '0;
            1: c.etype = 16'($urandom());
            default: c.etype = m_type[k];
        endcase
        return c;
    endfunction

    task automatic random_phase(int count, int idle, int stall);
        idle_pct  = idle;
        stall_pct = stall;
        repeat (count) send_cmd(random_cmd());
    endtask

    // directed checks of each command and most of its error paths
    task automatic test_directed();
        cmd_item_t c;
        idle_pct  = 0;
        stall_pct = 0;
        c = make_cmd(CMD_CREATE, 0, 32'h1, 32'h0, 16'h1);
        send_cmd(c);
        c = make_cmd(CMD_CREATE, 0, 32'h1, 32'h5, 16'h1);
        c.known = 1'b0;
        send_cmd(c);
        c = make_cmd(CMD_CREATE, 0, 32'hFF, 32'h5, 16'h1);
        c.valid = 32'h0F;
        send_cmd(c);
        send_cmd(make_cmd(CMD_CREATE, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
        send_cmd(make_cmd(CMD_CREATE, 0, 32'h0000_0006, 32'h0000_0001, 16'h0002));
        send_cmd(make_cmd(CMD_DUP, 0, 32'h0000_FFFF, 0, 0));
        send_cmd(make_cmd(CMD_DUP, 1, 32'hFFFF_FFFF, 0, 0));
        c = make_cmd(CMD_DUP, 0, 32'hFFFF_FFFF, 0, 0);
        c.valid = 32'h1;
        send_cmd(c);
        send_cmd(make_cmd(CMD_RESTRICT, 2, 32'h0000_00FF, 0, 0));
        send_cmd(make_cmd(CMD_RESTRICT, 2, 32'h0001_0000, 0, 0));
        send_cmd(make_cmd(CMD_REMOVE, 2, 32'h0000_000F, 0, 0));
        c = make_cmd(CMD_VERIFY, 0, 32'hFFFF_FFFF, 0, 0);
        c.etype = 16'hFFFF;
        send_cmd(c);
        c.etype = 16'h0002;
        send_cmd(c);
        c = make_cmd(CMD_VERIFY, 2, 32'h0000_0F00, 0, 0);
        send_cmd(c);
        send_cmd(make_cmd(CMD_TAKE, 0, 0, 0, 0));
        c = make_cmd(CMD_VERIFY, 0, 0, 0, 0);
        c.gen = 31'd0;
        send_cmd(c);
        c = make_cmd(CMD_VERIFY, 32'hFFFF_FFFF, 0, 0, 0);
        c.gen = GEN_MAX;
        send_cmd(c);
        send_cmd(make_cmd(CMD_VERIFY, SLOTS, 0, 0, 0));
        send_cmd(make_cmd(3'd7, 1, 0, 0, 0));
        send_cmd(make_cmd(CMD_CREATE, 0, 32'h3, 32'h77, 16'h3));
        send_cmd(make_cmd(CMD_CLEAR, 0, 0, 0, 0));
        send_cmd(make_cmd(CMD_VERIFY, 1, 0, 0, 0));
    endtask

    // duplicate with an empty mask and with the widest mask
    task automatic test_dup_mask();
        write_dup_mask(32'h0);
        idle_pct  = 0;
        stall_pct = 0;
        send_cmd(make_cmd(CMD_CREATE, 0, 32'hFFFF_FFFF, 32'h99, 16'h1));
        send_cmd(make_cmd(CMD_DUP, m_head == LINK_NONE ? 0 : 0, 32'hFFFF_FFFF, 0, 0));
        write_dup_mask(32'hFFFF_FFFF);
        send_cmd(make_cmd(CMD_CREATE, 0, 32'h8000_0000, 32'h9A, 16'h1));
        send_cmd(make_cmd(CMD_DUP, 1, 32'hFFFF_FFFF, 0, 0));
    endtask

    // fill every slot, then hit the full table
    task automatic test_table_full();
        idle_pct  = 0;
        stall_pct = 0;
        send_cmd(make_cmd(CMD_CLEAR, 0, 0, 0, 0));
        for (int i = 0; i < SLOTS + 2; i++)
            send_cmd(make_cmd(CMD_CREATE, 0, 32'h1, i + 1, 16'h2));
        send_cmd(make_cmd(CMD_DUP, 5, 32'h1, 0, 0));
        send_cmd(make_cmd(CMD_TAKE, 7, 0, 0, 0));
        send_cmd(make_cmd(CMD_CREATE, 0, 32'h1, 32'hAB, 16'h2));
        send_cmd(make_cmd(CMD_CLEAR, 0, 0, 0, 0));
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        wait_drained();
        idle_pct    = 0;
        stall_pct   = 0;
        hold_cycles = 300;
        repeat (20) send_cmd(random_cmd());
    endtask

    task automatic test_random();
        write_dup_mask(32'h0000_0003);
        random_phase(150, 0, 0);
        write_dup_mask(32'hFFFF_FFFF);
        random_phase(150, 85, 0);
        write_dup_mask($urandom());
        random_phase(150, 0, 85);
        write_dup_mask(32'h0000_0001);
        random_phase(150, 15, 15);
    endtask

    initial
    begin
        rst_n             = 1'b0;
        cfg_valid         = 1'b0;
        cfg_data          = '0;
        in_valid          = 1'b0;
        command           = '0;
        slot_index        = '0;
        handle_generation = '0;
        rights_operand    = '0;
        new_object        = '0;
        object_type       = '0;
        type_known        = 1'b0;
        type_valid_rights = '0;
        wanted_type       = '0;
        out_ready         = 1'b0;
        mismatches        = 0;
        idle_pct          = 0;
        stall_pct         = 0;
        hold_cycles       = 0;
        table_reset();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_dup_mask();
        test_table_full();
        test_backpressure();
        test_random();
        wait_drained();

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
